// File: rtl/c2s_pkg.sv
package c2s_pkg;

  localparam int COORD_W = 24;
  localparam int STAGES  = 16;
  // Datapath: coordinates scaled by 2^16, headroom for CORDIC gain and rotation
  localparam int W       = COORD_W + 20;
  // Q30 angle, signed, holds up to a full turn
  localparam int A_W     = 34;

  localparam logic signed [A_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [A_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [A_W-1:0] TWO_PI_Q30  = 34'sd6746518852;
  localparam logic signed [31:0]    GAIN_Q30    = 32'sd1768195363;
  localparam logic [30:0]           DEG_MUL     = 31'd961263669;
  localparam logic [30:0]           RAD_MUL     = 31'd1073741824;
  localparam logic [15:0]           FULL_RAD    = 16'd25736;
  localparam logic [15:0]           FULL_DEG    = 16'd23040;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_Z_AXIS = 2'd1,
    ST_ZERO   = 2'd2
  } status_t;

  // travels alongside a CORDIC pass
  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic                      y_neg;
    status_t                   cls;
    logic signed [A_W-1:0]     phi_a;
  } side_t;

  function automatic logic signed [A_W-1:0] atan_q30(input int i);
    logic signed [A_W-1:0] r;
    case (i)
      0: r = 34'sd843314856;
      1: r = 34'sd497837829;
      2: r = 34'sd263043836;
      3: r = 34'sd133525158;
      4: r = 34'sd67021686;
      5: r = 34'sd33543515;
      6: r = 34'sd16775850;
      7: r = 34'sd8388437;
      8: r = 34'sd4194282;
      9: r = 34'sd2097149;
      default: r = (i <= 30) ? A_W'(64'sd1 <<< (30 - i)) : '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [A_W-1:0] clamp_pi(input logic signed [A_W-1:0] a);
    logic signed [A_W-1:0] r;
    if (a < 0) begin
      r = '0;
    end else if (a > PI_Q30) begin
      r = PI_Q30;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

// File: rtl/c2s_cordic_pass.sv
module c2s_cordic_pass (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_v,
  input  logic signed [c2s_pkg::W-1:0]   in_x,
  input  logic signed [c2s_pkg::W-1:0]   in_y,
  input  c2s_pkg::side_t                 in_side,
  output logic                           out_v,
  output logic signed [c2s_pkg::W-1:0]   out_mag,
  output logic signed [c2s_pkg::A_W-1:0] out_ang,
  output c2s_pkg::side_t                 out_side
);
  import c2s_pkg::*;

  logic                  v_r [0:STAGES];
  logic signed [W-1:0]   x_r [0:STAGES];
  logic signed [W-1:0]   y_r [0:STAGES];
  logic signed [A_W-1:0] a_r [0:STAGES];
  side_t                 s_r [0:STAGES];

  // pre-rotation by -pi/2 for the left half plane, angle starting at +pi/2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
    if (en) begin
      s_r[0] <= in_side;
      if (in_x < 0) begin
        x_r[0] <= in_y;
        y_r[0] <= -in_x;
        a_r[0] <= HALF_PI_Q30;
      end else begin
        x_r[0] <= in_x;
        y_r[0] <= in_y;
        a_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [W-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
      if (en) begin
        s_r[i+1] <= s_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          a_r[i+1] <= a_r[i] + atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          a_r[i+1] <= a_r[i] - atan_q30(i);
        end
      end
    end
  end

  assign out_v    = v_r[STAGES];
  assign out_mag  = x_r[STAGES];
  assign out_ang  = clamp_pi(a_r[STAGES]);
  assign out_side = s_r[STAGES];

endmodule

// File: rtl/cartesian_to_spherical.sv
// Channel   Direction  Handshake            Beat
// in_       input      in_valid / in_stall  x_coord, y_coord, z_coord
// out_      output     out_valid/out_stall  theta, phi, status
// cfg_      input      cfg_we               cfg_wdata[0] = angle_units
//
// One beat per cycle sustained while out_stall is low; the delay is set mostly by
// the two chained CORDIC vectoring passes, one register per iteration.
// Synchronous active-low reset clears valid bits and angle_units.
// The whole pipeline freezes while a result is held under out_stall;
// in_stall is raised exactly then, so nothing is dropped or repeated.
module cartesian_to_spherical (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [c2s_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [c2s_pkg::COORD_W-1:0] in_y_coord,
  input  logic signed [c2s_pkg::COORD_W-1:0] in_z_coord,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [13:0]                      out_theta,
  output logic [14:0]                      out_phi,
  output logic [1:0]                       out_status,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata
);
  import c2s_pkg::*;

  localparam int PAD = W - COORD_W - 16;

  logic adv;
  logic units_r;

  // global advance: move whenever the output slot is free or being taken
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      units_r <= 1'b0;
    end else if (cfg_we) begin
      units_r <= cfg_wdata;
    end
  end

  // ---- input stage: scale by 2^16, fold y to the upper half plane, classify
  logic                v_in_r;
  logic signed [W-1:0] x_in_r, y_in_r;
  side_t               s_in_r;
  logic signed [W-1:0] xs, ys;

  assign xs = {{PAD{in_x_coord[COORD_W-1]}}, in_x_coord, 16'b0};
  assign ys = {{PAD{in_y_coord[COORD_W-1]}}, in_y_coord, 16'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_in_r <= 1'b0;
    end else if (adv) begin
      v_in_r <= in_valid;
    end
    if (adv) begin
      x_in_r        <= xs;
      y_in_r        <= in_y_coord[COORD_W-1] ? -ys : ys;
      s_in_r.z      <= in_z_coord;
      s_in_r.y_neg  <= in_y_coord[COORD_W-1];
      s_in_r.phi_a  <= '0;
      if (in_x_coord == '0 && in_y_coord == '0) begin
        s_in_r.cls <= (in_z_coord == '0) ? ST_ZERO : ST_Z_AXIS;
      end else begin
        s_in_r.cls <= ST_OK;
      end
    end
  end

  // ---- pass 1: azimuth and radius
  logic                  v1;
  logic signed [W-1:0]   rho1;
  logic signed [A_W-1:0] a1;
  side_t                 s1;

  c2s_cordic_pass u_pass_phi (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_v     (v_in_r),
    .in_x     (x_in_r),
    .in_y     (y_in_r),
    .in_side  (s_in_r),
    .out_v    (v1),
    .out_mag  (rho1),
    .out_ang  (a1),
    .out_side (s1)
  );

  // ---- gain stage: z * K, mirror azimuth for negative y
  logic                      v_g_r;
  logic signed [W-1:0]       zk_r, rho_r;
  side_t                     s_g_r;
  side_t                     s_g_nxt;
  logic signed [COORD_W+31:0] zp;

  assign zp = s1.z * GAIN_Q30;

  always_comb begin
    s_g_nxt       = s1;
    s_g_nxt.phi_a = s1.y_neg ? (TWO_PI_Q30 - a1) : a1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_g_r <= 1'b0;
    end else if (adv) begin
      v_g_r <= v1;
    end
    if (adv) begin
      zk_r  <= W'(zp >>> 14);
      rho_r <= rho1;
      s_g_r <= s_g_nxt;
    end
  end

  // ---- pass 2: polar angle from (z*K, rho)
  logic                  v2;
  logic signed [W-1:0]   mag2;
  logic signed [A_W-1:0] a2;
  side_t                 s2;

  c2s_cordic_pass u_pass_theta (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_v     (v_g_r),
    .in_x     (zk_r),
    .in_y     (rho_r),
    .in_side  (s_g_r),
    .out_v    (v2),
    .out_mag  (mag2),
    .out_ang  (a2),
    .out_side (s2)
  );

  // ---- unit conversion: a * M + 2^47, special cases substituted first
  logic                  v_u_r;
  logic [63:0]           th_p_r, ph_p_r;
  status_t               cls_u_r;
  logic                  units_u_r;
  logic signed [A_W-1:0] th_sel, ph_sel;
  logic [30:0]           mul;
  logic                  mag_sign;

  assign mag_sign = mag2[W-1]; // magnitude of pass 2 is not needed beyond this
  assign mul = units_r ? DEG_MUL : RAD_MUL;

  always_comb begin
    case (s2.cls)
      ST_ZERO: begin
        th_sel = '0;
        ph_sel = '0;
      end
      ST_Z_AXIS: begin
        th_sel = (s2.z < 0) ? PI_Q30 : '0;
        ph_sel = '0;
      end
      default: begin
        th_sel = a2;
        ph_sel = s2.phi_a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_u_r <= 1'b0;
    end else if (adv) begin
      v_u_r <= v2;
    end
    if (adv) begin
      th_p_r    <= {31'b0, th_sel[32:0]} * {33'b0, mul} + (64'd1 << 47);
      ph_p_r    <= {31'b0, ph_sel[32:0]} * {33'b0, mul} + (64'd1 << 47);
      cls_u_r   <= s2.cls;
      units_u_r <= units_r | (mag_sign & 1'b0);
    end
  end

  // ---- output register: round off, wrap a full turn to zero
  logic [15:0] ph_u;
  assign ph_u = ph_p_r[63:48];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v_u_r;
    end
    if (adv) begin
      out_theta  <= th_p_r[61:48];
      out_phi    <= (ph_u >= (units_u_r ? FULL_DEG : FULL_RAD)) ? '0 : ph_u[14:0];
      out_status <= cls_u_r;
    end
  end

  // ---- checks
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow held output");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_Z_AXIS || out_status == ST_ZERO))
    else $error("illegal status code");

  a_special_phi_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_phi == '0))
    else $error("phi nonzero on z axis or zero vector");

  a_zero_theta: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_ZERO) |-> (out_theta == '0))
    else $error("theta nonzero for zero vector");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import c2s_pkg::*;

  localparam int  CW       = COORD_W;
  localparam int  LATENCY  = 2 * STAGES + 6;
  localparam int  LIMIT    = 400000;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint PI      = 64'sd3373259426;
  localparam longint TWO_PI  = 64'sd6746518852;
  localparam longint GAIN    = 64'sd1768195363;
  localparam longint ATAN_HEAD [10] = '{843314856, 497837829, 263043836, 133525158,
    67021686, 33543515, 16775850, 8388437, 4194282, 2097149};

  typedef struct {
    logic [13:0] theta;
    logic [14:0] phi;
    status_t     status;
  } angles_t;

  typedef struct {
    logic signed [CW-1:0] x, y, z;
    bit                   known;
    logic [13:0]          th_rad, th_deg;
    logic [14:0]          phi;
    status_t              status;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_x_coord = '0, in_y_coord = '0, in_z_coord = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [13:0] out_theta;
  logic [14:0] out_phi;
  logic [1:0]  out_status;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  angles_t pending_angles[$];
  int      errors = 0;
  int      cycles = 0;
  int      send_idle_pct = 0, recv_idle_pct = 0;
  bit      deg_mode = 1'b0;   // tb copy of angle_units
  vec_row_t dir_rows[$];

  cartesian_to_spherical dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_x_coord, .in_y_coord, .in_z_coord,
    .out_valid, .out_stall, .out_theta, .out_phi, .out_status, .cfg_we, .cfg_wdata
  );

  always #2 clk = ~clk;

  // Watchdog: covers slowest legal run several times over.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------- predictor ----------------
  function automatic longint atan_step(input int i);
    if (i < 10) return ATAN_HEAD[i];
    if (i <= 30) return 64'sd1 <<< (30 - i);
    return 0;
  endfunction

  // CORDIC vectoring on (x, y), y >= 0; angle in Q30, magnitude carries the gain
  function automatic longint vector_angle(input longint xi, input longint yi,
                                          output longint mag);
    longint x, y, a, dx, dy, t;
    x = xi; y = yi; a = 0;
    if (x < 0) begin
      t = y; y = -x; x = t; a = HALF_PI;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; a = a + atan_step(i);
      end else begin
        x = x - dx; y = y + dy; a = a - atan_step(i);
      end
    end
    if (a < 0) a = 0;
    if (a > PI) a = PI;
    mag = x;
    return a;
  endfunction

  // Q30 radians -> output units, round half up
  function automatic longint unsigned q30_to_units(input longint a, input bit deg);
    longint unsigned m;
    m = deg ? 64'd961263669 : (64'd1 << 30);
    return (longint'(unsigned'(a)) * m + (64'd1 << 47)) >> 48;
  endfunction

  function automatic angles_t predict_angles(input logic signed [CW-1:0] x,
                                             input logic signed [CW-1:0] y,
                                             input logic signed [CW-1:0] z,
                                             input bit deg);
    angles_t r;
    longint xs, ys, zs, ay, rho, unused, a, th, zk;
    longint unsigned ph, full;
    xs = x; ys = y; zs = z;
    r.theta = '0; r.phi = '0; r.status = ST_OK;
    if (xs == 0 && ys == 0) begin
      if (zs == 0) begin
        r.status = ST_ZERO;
      end else begin
        r.status = ST_Z_AXIS;
        r.theta = 14'(q30_to_units(zs > 0 ? 0 : PI, deg));
      end
    end else begin
      ay = ys < 0 ? -ys : ys;
      full = deg ? 23040 : 25736;
      a = vector_angle(xs * 65536, ay * 65536, rho);
      if (ys < 0) a = TWO_PI - a;
      ph = q30_to_units(a, deg);
      if (ph >= full) ph = 0;
      zk = (zs * GAIN) >>> 14;
      th = vector_angle(zk, rho, unused);
      r.theta = 14'(q30_to_units(th, deg));
      r.phi = 15'(ph);
    end
    return r;
  endfunction

  // ---------------- result checking ----------------
  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    angles_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_angles.size() == 0) begin
        report("unexpected beat", out_theta, -1);
      end else begin
        e = pending_angles.pop_front();
        if (out_theta !== e.theta) report("theta", out_theta, e.theta);
        if (out_phi !== e.phi) report("phi", out_phi, e.phi);
        if (out_status !== e.status) report("status", out_status, e.status);
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  // ---------------- stimulus ----------------
  task automatic send_vector(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic signed [CW-1:0] z, input bit known,
                             input angles_t typed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_coord <= x; in_y_coord <= y; in_z_coord <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_angles.push_back(known ? typed : predict_angles(x, y, z, deg_mode));
  endtask

  // Sender holds off until every beat is back, plus pipeline depth.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_units(input bit v);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    deg_mode = v;
  endtask

  function automatic void add_row(input longint x, input longint y, input longint z,
                                  input bit known = 0, input int thr = 0, input int thd = 0,
                                  input status_t st = ST_OK);
    vec_row_t r;
    r.x = CW'(x); r.y = CW'(y); r.z = CW'(z); r.known = known;
    r.th_rad = 14'(thr); r.th_deg = 14'(thd); r.phi = '0; r.status = st;
    dir_rows.push_back(r);
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(7))
      0: return '0;
      1: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      2: return $urandom_range(1) ? CW'($urandom_range(255)) : -CW'($urandom_range(255));
      3: return $urandom_range(1) ? CW'(1) : -CW'(1);
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic walk_directed();
    angles_t t;
    foreach (dir_rows[i]) begin
      t.theta = deg_mode ? dir_rows[i].th_deg : dir_rows[i].th_rad;
      t.phi = dir_rows[i].phi;
      t.status = dir_rows[i].status;
      send_vector(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].known, t);
    end
  endtask

  task automatic random_phase(input int n);
    logic signed [CW-1:0] x, y, z;
    angles_t blank;
    blank.theta = '0; blank.phi = '0; blank.status = ST_OK;
    for (int i = 0; i < n; i++) begin
      x = rand_coord(); y = rand_coord(); z = rand_coord();
      if ($urandom_range(9) == 0) begin
        x = '0; y = '0;   // z axis or origin
      end
      send_vector(x, y, z, 1'b0, blank);
    end
  endtask

  initial begin
    // zero vector, both z-axis directions, then extremes and quadrants
    add_row(0, 0, 0, 1, 0, 0, ST_ZERO);
    add_row(0, 0, 8388607, 1, 0, 0, ST_Z_AXIS);
    add_row(0, 0, 1, 1, 0, 0, ST_Z_AXIS);
    add_row(0, 0, -8388608, 1, 12868, 11520, ST_Z_AXIS);
    add_row(0, 0, -1, 1, 12868, 11520, ST_Z_AXIS);
    add_row(8388607, 0, 0);
    add_row(-8388608, 0, 0);
    add_row(0, 8388607, 0);
    add_row(0, -8388608, 0);
    add_row(1, -1, 0);        // azimuth of seven eighths of a turn
    add_row(8388607, -1, 0);  // may round up to a full turn -> 0
    add_row(-1, 0, 0);
    add_row(-1, -1, 1);
    add_row(8388607, 8388607, 8388607);
    add_row(-8388608, -8388608, -8388608);
    add_row(-8388608, 8388607, 8388607);
    add_row(8388607, -8388608, -8388608);
    add_row(1, 0, 8388607);
    add_row(1, 0, -8388608);
    add_row(1000, -2000, 3000);
    add_row(-5, 7, -9);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, radians from reset
    send_idle_pct = 38; recv_idle_pct = 58;
    walk_directed();
    drain();
    write_units(1'b1);
    walk_directed();
    drain();

    // random phases, one idle pattern and unit setting each
    write_units(1'b0);
    random_phase(480);
    drain();
    send_idle_pct = 58; recv_idle_pct = 38;
    write_units(1'b1);
    random_phase(480);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    write_units(1'b0);
    random_phase(490);
    drain();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
